// ===== hdl/sesh_pkg.sv =====
// Package for the session hello parser: field and status codes, layout constants,
// and the structs passed between the register file, the parse core and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sesh_pkg;

  // Layout of a session hello payload.
  localparam int unsigned NonceBytes = 32;
  localparam int unsigned HashBytes  = 32;
  localparam int unsigned IdMax      = 64;
  localparam int unsigned MfBytes    = 4;
  localparam int unsigned LenPos     = 1 + NonceBytes;
  localparam int unsigned IdStart    = LenPos + 1;
  localparam int unsigned MinSize    = 1 + NonceBytes + 1 + HashBytes + MfBytes;
  localparam int unsigned CountSat   = 255;

  // Printable range for device id characters.
  localparam logic [7:0] CharLow  = 8'h20;
  localparam logic [7:0] CharHigh = 8'h7e;

  // Register reset values.
  localparam logic [7:0]  RoleFirstRst  = 8'd0;
  localparam logic [7:0]  RoleSecondRst = 8'd1;
  localparam logic [31:0] MfLimitRst    = 32'd4194304;

  typedef enum logic [1:0] {
    REG_ROLE_FIRST  = 2'd0,
    REG_ROLE_SECOND = 2'd1,
    REG_MF_LIMIT    = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    KIND_ROLE     = 3'd0,
    KIND_NONCE    = 3'd1,
    KIND_LEN      = 3'd2,
    KIND_ID       = 3'd3,
    KIND_HASH     = 3'd4,
    KIND_MF       = 3'd5,
    KIND_UNPARSED = 3'd6
  } field_kind_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TRUNCATED  = 3'd1,
    ST_BAD_LEN    = 3'd2,
    ST_MISMATCH   = 3'd3,
    ST_BAD_ROLE   = 3'd4,
    ST_BAD_CHAR   = 3'd5,
    ST_BAD_MFRAME = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0]  role_first;
    logic [7:0]  role_second;
    logic [31:0] mf_limit;
  } cfg_t;

  typedef struct packed {
    field_kind_e kind;
    logic [5:0]  index;
    logic [7:0]  data;
    logic        done;
    status_e     status;
    logic [7:0]  role;
    logic [7:0]  id_len;
    logic [31:0] frame_cap;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/sesh_apb_regs.sv =====
// APB configuration registers of the session hello parser: role codes and max frame limit.
// Depends on sesh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sesh_apb_regs import sesh_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e sel_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign sel_idx = reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel_idx)
        REG_ROLE_FIRST:  cfg_d.role_first  = pwdata[7:0];
        REG_ROLE_SECOND: cfg_d.role_second = pwdata[7:0];
        REG_MF_LIMIT:    cfg_d.mf_limit    = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel_idx)
      REG_ROLE_FIRST:  prdata = {24'd0, cfg_q.role_first};
      REG_ROLE_SECOND: prdata = {24'd0, cfg_q.role_second};
      REG_MF_LIMIT:    prdata = cfg_q.mf_limit;
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.role_first  <= RoleFirstRst;
      cfg_q.role_second <= RoleSecondRst;
      cfg_q.mf_limit    <= MfLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/sesh_parse_core.sv =====
// Per-message state and single-pass byte classification with end-of-message status.
// Depends on sesh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sesh_parse_core import sesh_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       adv_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  input  wire cfg_t       cfg_i,
  output result_t         result_o
);

  logic [7:0]  count_q, count_d;
  logic [7:0]  role_q, role_d;
  logic [7:0]  len_q, len_d;
  logic        char_err_q, char_err_d;
  logic [31:0] mf_q, mf_d;

  logic [8:0]  pos;
  logic [8:0]  hash_start;
  logic [8:0]  mf_start;
  logic [8:0]  idx_wide;
  logic        len_ok_q;
  logic        len_ok_d;
  logic [9:0]  n_bytes;
  logic [9:0]  expected;
  field_kind_e kind;
  status_e     status;

  assign pos        = {1'b0, count_q};
  assign len_ok_q   = (len_q != 8'd0) && ({1'b0, len_q} <= 9'(IdMax));
  assign hash_start = 9'(IdStart) + {1'b0, len_q};
  assign mf_start   = hash_start + 9'(HashBytes);

  always_comb begin
    kind       = KIND_UNPARSED;
    idx_wide   = 9'd0;
    count_d    = count_q;
    role_d     = role_q;
    len_d      = len_q;
    char_err_d = char_err_q;
    mf_d       = mf_q;
    if (pos < 9'(CountSat)) begin
      count_d = count_q + 8'd1;
      priority if (pos == 9'd0) begin
        kind   = KIND_ROLE;
        role_d = byte_i;
      end else if (pos < 9'(LenPos)) begin
        kind     = KIND_NONCE;
        idx_wide = pos - 9'd1;
      end else if (pos == 9'(LenPos)) begin
        kind  = KIND_LEN;
        len_d = byte_i;
      end else if (len_ok_q) begin
        // Bytes past the declared layout fall through as unparsed.
        priority if (pos < hash_start) begin
          kind     = KIND_ID;
          idx_wide = pos - 9'(IdStart);
          if ((byte_i < CharLow) || (byte_i > CharHigh)) begin
            char_err_d = 1'b1;
          end
        end else if (pos < mf_start) begin
          kind     = KIND_HASH;
          idx_wide = pos - hash_start;
        end else if (pos < mf_start + 9'(MfBytes)) begin
          kind     = KIND_MF;
          idx_wide = pos - mf_start;
          mf_d     = {mf_q[23:0], byte_i};
        end else begin
          kind = KIND_UNPARSED;
        end
      end else begin
        kind = KIND_UNPARSED;
      end
    end
  end

  // Status is judged on the state including this byte.
  assign len_ok_d = (len_d != 8'd0) && ({1'b0, len_d} <= 9'(IdMax));
  assign n_bytes  = {2'b00, count_q} + 10'd1;
  assign expected = 10'(MinSize) + {2'b00, len_d};

  always_comb begin
    priority if (n_bytes < 10'(MinSize)) begin
      status = ST_TRUNCATED;
    end else if (!len_ok_d) begin
      status = ST_BAD_LEN;
    end else if ((pos >= 9'(CountSat)) || (n_bytes != expected)) begin
      status = ST_MISMATCH;
    end else if ((role_d != cfg_i.role_first) && (role_d != cfg_i.role_second)) begin
      status = ST_BAD_ROLE;
    end else if (char_err_d) begin
      status = ST_BAD_CHAR;
    end else if ((mf_d == 32'd0) || (mf_d > cfg_i.mf_limit)) begin
      status = ST_BAD_MFRAME;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    result_o.kind      = kind;
    result_o.index     = idx_wide[5:0];
    result_o.data      = byte_i;
    result_o.done      = last_i;
    result_o.status    = last_i ? status : ST_OK;
    result_o.role      = last_i ? role_d : 8'd0;
    result_o.id_len    = last_i ? len_d : 8'd0;
    result_o.frame_cap = last_i ? mf_d : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= 8'd0;
      role_q     <= 8'd0;
      len_q      <= 8'd0;
      char_err_q <= 1'b0;
      mf_q       <= 32'd0;
    end else if (adv_i) begin
      if (last_i) begin
        count_q    <= 8'd0;
        role_q     <= 8'd0;
        len_q      <= 8'd0;
        char_err_q <= 1'b0;
        mf_q       <= 32'd0;
      end else begin
        count_q    <= count_d;
        role_q     <= role_d;
        len_q      <= len_d;
        char_err_q <= char_err_d;
        mf_q       <= mf_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/session_hello_parser_unit.sv =====
// Channel    | Dir | Payload
// s_axis     | in  | tdata[7:0] data_byte, tlast last_byte
// m_axis     | out | tuser[2:0] field_kind, tdata fields (see port), tlast message_done
// apb        | in  | role_code_first @0x0, role_code_second @0x4, max frame limit @0x8
//
// One byte per cycle sustained while the result is not stalled; a byte taken into the input
// register passes through the classify/status logic into the result register, from which its
// result can be accepted.
// Reset clears the message state, the pipeline valids and loads the register defaults.
// A stalled result holds; the input register still takes one more byte behind it.
// Depends on sesh_pkg, sesh_apb_regs and sesh_parse_core.
`timescale 1ns / 1ps
`default_nettype none

module session_hello_parser_unit import sesh_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [5:0] field_index, [13:6] byte_out, [16:14] status, [24:17] role_value,
  // [32:25] id_length, [64:33] max frame value, [71:65] zero
  output logic [71:0]      m_axis_tdata,
  output logic [2:0]       m_axis_tuser,  // [2:0] field_kind
  output logic             m_axis_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t        cfg;
  result_t     core_res;
  result_t     out_q;
  logic        out_valid_q, out_valid_d;
  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        adv;

  sesh_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sesh_parse_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .cfg_i    (cfg),
    .result_o (core_res)
  );

  // A byte moves on when the result register is empty or being emptied.
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign in_valid_d    = s_axis_tready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d   = adv ? 1'b1 : (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (adv) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.done;
  assign m_axis_tdata  = {7'd0, out_q.frame_cap, out_q.id_len, out_q.role, out_q.status,
                          out_q.data, out_q.index};

  a_not_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.done) |-> (out_q.status == ST_OK && out_q.role == 8'd0
      && out_q.id_len == 8'd0 && out_q.frame_cap == 32'd0))
    else $error("result without done carries status fields");

  a_unparsed_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == KIND_UNPARSED) |-> (out_q.index == 6'd0))
    else $error("unparsed byte with nonzero index");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled while pipeline has room");

  a_held_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !adv) |=> ($stable(in_byte_q) && $stable(in_last_q)))
    else $error("held input byte changed");

endmodule

`default_nettype wire
